FILE: design/hpt_pkg.sv
package hpt_pkg;

   // operand and product widths of the shared digit-serial multiplier
   localparam int MUL_A_BITS = 40;
   localparam int MUL_B_BITS = 28;
   localparam int PROD_BITS  = 64;
   localparam int DIGIT_BITS = 4;

   // digits per operation: coefficient and sine/cosine (16 bit signed),
   // detector output (20 bit signed), loop gain (24 bit unsigned as 28 bit signed)
   localparam logic [2:0] NDIG_TAP  = 3'd4;
   localparam logic [2:0] NDIG_MIX  = 3'd4;
   localparam logic [2:0] NDIG_PD   = 3'd5;
   localparam logic [2:0] NDIG_GAIN = 3'd7;

   localparam int PD_BITS   = 20;
   localparam int GAIN_BITS = 24;
   localparam int PAIRS     = 8;

   localparam logic [1:0] CSR_REST_STEP  = 2'd0;
   localparam logic [1:0] CSR_PROP_GAIN  = 2'd1;
   localparam logic [1:0] CSR_INTEG_GAIN = 2'd2;

   localparam logic [31:0] REST_STEP_RESET  = 32'd536870912;
   localparam logic [23:0] PROP_GAIN_RESET  = 24'd106807;
   localparam logic [23:0] INTEG_GAIN_RESET = 24'd21361;

   typedef struct packed {
      logic       start;
      logic       keep;
      logic [2:0] ndig;
   } mul_ctl_type;

   // Hilbert coefficient magnitude at odd distance 2*i+1 from the center
   function automatic logic [14:0] tap_mag(logic [2:0] i);
      logic [14:0] m;
      case (i)
         3'd0: m = 15'd20690;
         3'd1: m = 15'd6449;
         3'd2: m = 15'd3375;
         3'd3: m = 15'd1953;
         3'd4: m = 15'd1127;
         3'd5: m = 15'd616;
         3'd6: m = 15'd305;
         default: m = 15'd138;
      endcase
      return m;
   endfunction

   function automatic logic signed [63:0] round_sar(logic signed [63:0] v, int unsigned s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // quarter-wave sine entry, evaluated at elaboration only
   function automatic logic [14:0] quarter_sine(int unsigned r, int unsigned ab);
      longint x;
      longint x2;
      longint p;
      longint y;
      x  = longint'(r) <<< (32 - ab);
      x2 = (x * x) >>> 30;
      p  = 64'sd172272;
      p  = -64'sd5026995 + ((p * x2) >>> 30);
      p  = 64'sd85569306 + ((p * x2) >>> 30);
      p  = -64'sd693598668 + ((p * x2) >>> 30);
      p  = 64'sd1686629713 + ((p * x2) >>> 30);
      y  = (p * x) >>> 30;
      y  = (y * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
      if (y < 0) y = 0;
      if (y > 32767) y = 32767;
      return y[14:0];
   endfunction

endpackage

FILE: design/hpt_digit_mul.sv
module hpt_digit_mul (
   input  logic                                     clock,
   input  logic                                     reset,
   input  hpt_pkg::mul_ctl_type                     ctl,
   input  logic signed [hpt_pkg::MUL_A_BITS-1:0]    a,
   input  logic signed [hpt_pkg::MUL_B_BITS-1:0]    b,
   output logic signed [hpt_pkg::PROD_BITS-1:0]     prod,
   output logic                                     busy
);
   import hpt_pkg::*;

   logic                        busy_ff;
   logic [2:0]                  cnt_ff;
   logic signed [PROD_BITS-1:0] a_ff;
   logic signed [MUL_B_BITS-1:0] b_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] term;
   logic [DIGIT_BITS-1:0]       dig;
   logic                        last;

   assign dig  = b_ff[DIGIT_BITS-1:0];
   assign last = (cnt_ff == 3'd1);

   // the top digit carries negative weight on its high bit
   always_comb begin
      term = '0;
      if (dig[0]) term = term + a_ff;
      if (dig[1]) term = term + (a_ff <<< 1);
      if (dig[2]) term = term + (a_ff <<< 2);
      if (dig[3]) term = last ? term - (a_ff <<< 3) : term + (a_ff <<< 3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= ctl.ndig;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 3'd1;
         busy_ff <= !last;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         a_ff    <= PROD_BITS'(a);
         b_ff    <= b;
         prod_ff <= ctl.keep ? prod_ff : '0;
      end else if (busy_ff) begin
         prod_ff <= prod_ff + term;
         a_ff    <= a_ff <<< DIGIT_BITS;
         b_ff    <= b_ff >>> DIGIT_BITS;
      end
   end

   assign prod = prod_ff;
   assign busy = busy_ff;

endmodule

FILE: design/hpt_delay_ram.sv
module hpt_delay_ram #(
   parameter int DEPTH = 31,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // entries never written read as zero
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/hpt_sine_rom.sv
module hpt_sine_rom #(
   parameter int ADDR_BITS = 10
) (
   input  logic                 clock,
   input  logic [ADDR_BITS-1:0] addr,
   output logic signed [15:0]   data
);
   import hpt_pkg::*;

   localparam int QB = ADDR_BITS - 2;
   localparam int QN = 1 << QB;

   logic [14:0]       qtab [QN+1];
   logic [1:0]        quad;
   logic [QB-1:0]     r;
   logic [QB:0]       ridx;
   logic [14:0]       mag;
   logic signed [15:0] data_ff;

   for (genvar i = 0; i <= QN; i++) begin : g_tab
      assign qtab[i] = quarter_sine(i, ADDR_BITS);
   end

   assign quad = addr[ADDR_BITS-1 -: 2];
   assign r    = addr[QB-1:0];
   assign ridx = quad[0] ? ((QB+1)'(QN) - {1'b0, r}) : {1'b0, r};
   assign mag  = qtab[ridx];

   always_ff @(posedge clock) begin
      data_ff <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   assign data = data_ff;

endmodule

FILE: design/hilbert_pll_tracker.sv
// Hilbert-transform phase-locked loop that tracks a tone in an audio stream.
// req_ channel: one Q1.15 sample per beat (low SAMPLE_BITS bits, zero-extended).
// rsp_ channel: one beat per sample: VCO cosine and sine at the phase before
// the update, and the phase step applied (rest step plus loop correction).
// csr_ port: write rest_step (0), prop_gain (1), integ_gain (2) while idle;
// other indexes are ignored.
// All fifteen multiplications (eight coefficient pairs, four mixer products, the
// detector product and two loop gains) share one multiplier that consumes a 4-bit
// digit per cycle. req_stall stays high until the sample's work is done.
// A finished response waits in the output register while rsp_stall is high;
// the next sample may already be taken and processed, and its result holds
// until the register frees up.
// Reset clears the delay line, integrator, phase and write pointer and loads
// the default register values.
module hilbert_pll_tracker #(
   parameter int TAPS           = 31,
   parameter int SINE_ADDR_BITS = 10,
   parameter int SAMPLE_BITS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_received_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_vco_cosine,
   output logic signed [15:0] rsp_vco_sine,
   output logic [31:0]        rsp_phase_step,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import hpt_pkg::*;

   localparam int CENTER = (TAPS - 1) / 2;
   localparam int PTR    = $clog2(TAPS);
   localparam int FRAC   = SAMPLE_BITS - 1;
   localparam int XW     = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
   localparam int SIW    = SAMPLE_BITS + 3;
   localparam int KW     = PTR + 2;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b00000000001,
      ST_RD_POS   = 11'b00000000010,
      ST_RD_NEG   = 11'b00000000100,
      ST_TAP      = 11'b00000001000,
      ST_TAP_WAIT = 11'b00000010000,
      ST_RD_REAL  = 11'b00000100000,
      ST_ROM_COS  = 11'b00001000000,
      ST_MIX      = 11'b00010000000,
      ST_MIX_WAIT = 11'b00100000000,
      ST_STEP     = 11'b01000000000,
      ST_OUT      = 11'b10000000000
   } state_type;

   state_type state_ff;
   logic [PTR-1:0]  wp_ff;
   logic [2:0]      pair_ff;
   logic [2:0]      op_ff;

   logic [31:0]     rest_ff;
   logic [23:0]     pgain_ff;
   logic [23:0]     igain_ff;
   logic signed [31:0] integ_ff;
   logic [31:0]     phase_ff;

   logic signed [SAMPLE_BITS-1:0] pos_ff;
   logic signed [SAMPLE_BITS-1:0] real_ff;
   logic signed [SIW-1:0]         simag_ff;
   logic signed [15:0]            sin_ff;
   logic signed [15:0]            cos_ff;
   logic signed [PD_BITS-1:0]     pdre_ff;
   logic signed [MUL_A_BITS-1:0]  q_ff;
   logic signed [31:0]            sig_ff;
   logic [31:0]                   step_ff;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_cos_ff;
   logic signed [15:0] rsp_sin_ff;
   logic [31:0]        rsp_step_ff;

   logic               accept;
   logic [XW-1:0]      raw_ext;
   logic [SAMPLE_BITS-1:0] sample;

   logic [KW-1:0]      m_dist;
   logic               pos_there;
   logic               neg_there;
   logic [KW-1:0]      k_sel;
   logic [KW-1:0]      idx_sum;
   logic [PTR-1:0]     rd_addr;
   logic [SAMPLE_BITS-1:0] rd_data;

   logic [SINE_ADDR_BITS-1:0] sin_addr;
   logic [SINE_ADDR_BITS-1:0] rom_addr;
   logic signed [15:0]        rom_data;

   mul_ctl_type                  mctl;
   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]  prod;
   logic                         mul_busy;

   logic signed [SAMPLE_BITS:0]  diff;
   logic signed [PD_BITS-1:0]    pd_now;
   logic signed [PROD_BITS-1:0]  iterm;
   logic signed [PROD_BITS-1:0]  pterm;
   logic signed [41:0]           sig_sum;
   logic signed [31:0]           sig_sat;
   logic signed [43:0]           total;
   logic [31:0]                  total_sat;

   assign accept  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign raw_ext = XW'($unsigned(req_received_sample));
   assign sample  = raw_ext[SAMPLE_BITS-1:0];

   // ring index of the sample k steps back from the newest one
   assign m_dist    = KW'({pair_ff, 1'b1});
   assign pos_there = (CENTER + int'(m_dist)) <= (TAPS - 1);
   assign neg_there = int'(m_dist) <= CENTER;

   always_comb begin
      k_sel = KW'(CENTER);
      case (state_ff)
         ST_RD_POS: k_sel = pos_there ? KW'(CENTER) + m_dist : '0;
         ST_RD_NEG: k_sel = neg_there ? KW'(CENTER) - m_dist : '0;
         default:   k_sel = KW'(CENTER);
      endcase
      idx_sum = KW'(wp_ff) + KW'(TAPS) - k_sel;
      if (idx_sum >= KW'(TAPS)) idx_sum = idx_sum - KW'(TAPS);
   end
   assign rd_addr = idx_sum[PTR-1:0];

   hpt_delay_ram #(
      .DEPTH (TAPS),
      .WIDTH (SAMPLE_BITS)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data (sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sin_addr = phase_ff[31 -: SINE_ADDR_BITS];
   assign rom_addr = (state_ff == ST_ROM_COS)
                     ? sin_addr + SINE_ADDR_BITS'(1 << (SINE_ADDR_BITS - 2)) : sin_addr;

   hpt_sine_rom #(
      .ADDR_BITS (SINE_ADDR_BITS)
   ) u_rom (
      .clock (clock),
      .addr  (rom_addr),
      .data  (rom_data)
   );

   assign diff   = (SAMPLE_BITS+1)'(pos_ff)
                 - (neg_there ? (SAMPLE_BITS+1)'($signed(rd_data)) : '0);
   assign pd_now = PD_BITS'(round_sar(prod, FRAC));
   assign iterm  = round_sar(prod, 24);
   assign pterm  = round_sar(prod, 24);

   assign sig_sum = 42'(integ_ff) + $signed(iterm[41:0]);
   always_comb begin
      if (sig_sum > 42'sd2147483647)       sig_sat = 32'sh7FFFFFFF;
      else if (sig_sum < -42'sd2147483648) sig_sat = 32'sh80000000;
      else                                 sig_sat = sig_sum[31:0];
   end

   assign total = $signed({12'd0, rest_ff}) + 44'(sig_ff) + $signed(pterm[43:0]);
   always_comb begin
      if (total < 0)                      total_sat = '0;
      else if (total > 44'sh0FFFFFFFF)    total_sat = 32'hFFFFFFFF;
      else                                total_sat = total[31:0];
   end

   // multiplier operand selection
   always_comb begin
      mctl  = '0;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_TAP: begin
            mctl.start = 1'b1;
            mctl.keep  = (pair_ff != 3'd0);
            mctl.ndig  = NDIG_TAP;
            mul_a = MUL_A_BITS'(diff);
            mul_b = MUL_B_BITS'($signed({1'b0, tap_mag(pair_ff)}));
         end
         ST_MIX: begin
            mctl.start = 1'b1;
            case (op_ff)
               3'd0: begin
                  mctl.ndig = NDIG_MIX;
                  mul_a = MUL_A_BITS'(real_ff);
                  mul_b = MUL_B_BITS'(rom_data);
               end
               3'd1: begin
                  mctl.keep = 1'b1;
                  mctl.ndig = NDIG_MIX;
                  mul_a = MUL_A_BITS'(simag_ff);
                  mul_b = MUL_B_BITS'(sin_ff);
               end
               3'd2: begin
                  mctl.ndig = NDIG_MIX;
                  mul_a = MUL_A_BITS'(simag_ff);
                  mul_b = MUL_B_BITS'(cos_ff);
               end
               3'd3: begin
                  mctl.keep = 1'b1;
                  mctl.ndig = NDIG_MIX;
                  mul_a = -MUL_A_BITS'(real_ff);
                  mul_b = MUL_B_BITS'(sin_ff);
               end
               3'd4: begin
                  mctl.ndig = NDIG_PD;
                  mul_a = MUL_A_BITS'(pdre_ff);
                  mul_b = MUL_B_BITS'(pd_now);
               end
               3'd5: begin
                  mctl.ndig = NDIG_GAIN;
                  mul_a = $signed(prod[MUL_A_BITS-1:0]);
                  mul_b = $signed({4'd0, igain_ff});
               end
               default: begin
                  mctl.ndig = NDIG_GAIN;
                  mul_a = q_ff;
                  mul_b = $signed({4'd0, pgain_ff});
               end
            endcase
         end
         default: begin
            mctl = '0;
         end
      endcase
   end

   hpt_digit_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mctl),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod),
      .busy  (mul_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff  <= REST_STEP_RESET;
         pgain_ff <= PROP_GAIN_RESET;
         igain_ff <= INTEG_GAIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_REST_STEP:  rest_ff  <= csr_data;
            CSR_PROP_GAIN:  pgain_ff <= csr_data[GAIN_BITS-1:0];
            CSR_INTEG_GAIN: igain_ff <= csr_data[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         pair_ff      <= '0;
         op_ff        <= '0;
         integ_ff     <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  pair_ff  <= '0;
                  state_ff <= ST_RD_POS;
               end
            end
            ST_RD_POS: state_ff <= ST_RD_NEG;
            ST_RD_NEG: state_ff <= ST_TAP;
            ST_TAP:    state_ff <= ST_TAP_WAIT;
            ST_TAP_WAIT: begin
               if (!mul_busy) begin
                  if (pair_ff == 3'(PAIRS - 1)) begin
                     state_ff <= ST_RD_REAL;
                  end else begin
                     pair_ff  <= pair_ff + 3'd1;
                     state_ff <= ST_RD_POS;
                  end
               end
            end
            ST_RD_REAL: state_ff <= ST_ROM_COS;
            ST_ROM_COS: begin
               op_ff    <= '0;
               state_ff <= ST_MIX;
            end
            ST_MIX: begin
               if (op_ff == 3'd6) integ_ff <= sig_sat;
               state_ff <= ST_MIX_WAIT;
            end
            ST_MIX_WAIT: begin
               if (!mul_busy) begin
                  if (op_ff == 3'd6) begin
                     state_ff <= ST_STEP;
                  end else begin
                     op_ff    <= op_ff + 3'd1;
                     state_ff <= ST_MIX;
                  end
               end
            end
            ST_STEP: begin
               phase_ff <= phase_ff + total_sat;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  wp_ff    <= (wp_ff == PTR'(TAPS - 1)) ? '0 : wp_ff + PTR'(1);
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_RD_NEG:  pos_ff <= pos_there ? $signed(rd_data) : '0;
         ST_RD_REAL: simag_ff <= SIW'(round_sar(prod, 15));
         ST_ROM_COS: begin
            real_ff <= $signed(rd_data);
            sin_ff  <= rom_data;
         end
         ST_MIX: begin
            case (op_ff)
               3'd0: cos_ff  <= rom_data;
               3'd2: pdre_ff <= pd_now;
               3'd5: q_ff    <= $signed(prod[MUL_A_BITS-1:0]);
               3'd6: sig_ff  <= sig_sat;
               default: ;
            endcase
         end
         ST_STEP: step_ff <= total_sat;
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_cos_ff  <= cos_ff;
               rsp_sin_ff  <= sin_ff;
               rsp_step_ff <= step_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_vco_cosine = rsp_cos_ff;
   assign rsp_vco_sine   = rsp_sin_ff;
   assign rsp_phase_step = rsp_step_ff;

endmodule

FILE: test/tb_hilbert_pll_tracker.sv
module tb_hilbert_pll_tracker;
   import hpt_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int RING = 31;
   localparam int CENTER_TAP = 15;

   typedef struct {
      logic signed [15:0] cosine;
      logic signed [15:0] sine;
      logic [31:0]        step;
   } vco_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_received_sample = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_vco_cosine;
   logic signed [15:0] rsp_vco_sine;
   logic [31:0]        rsp_phase_step;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   hilbert_pll_tracker DUT (.*);

   // loop state mirrored in the testbench
   logic [31:0] rest_step_q;
   logic [23:0] prop_gain_q;
   logic [23:0] integ_gain_q;
   longint      ring [RING];
   longint      integ_acc;
   logic [31:0] vco_phase_q;
   int          ring_ptr;

   vco_beat_type pending_vco [$];
   int          errors = 0;
   int          burst_left = 0;
   int          hold_request = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #30000000;
      $display("status: fail");
      $finish;
   end

   function automatic longint round_half_up(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint quarter_wave(int r);
      longint x, x2, p, y;
      longint coef [4] = '{-64'sd5026995, 64'sd85569306, -64'sd693598668, 64'sd1686629713};
      x  = longint'(r) <<< 22;
      x2 = (x * x) >>> 30;
      p  = 64'sd172272;
      foreach (coef[i]) p = coef[i] + ((p * x2) >>> 30);
      y = (p * x) >>> 30;
      y = (y * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
      if (y < 0) y = 0;
      if (y > 32767) y = 32767;
      return y;
   endfunction

   function automatic longint sine_lookup(logic [9:0] addr);
      int r;
      longint v;
      r = addr[7:0];
      if (addr[8]) r = 256 - r;
      v = quarter_wave(r);
      return addr[9] ? -v : v;
   endfunction

   function automatic longint hilbert_coef(int k);
      int d, m;
      d = k - CENTER_TAP;
      m = d < 0 ? -d : d;
      if (m % 2 == 0 || m > 15) return 0;
      case (m)
         1: return d < 0 ? -20690 : 20690;
         3: return d < 0 ? -6449 : 6449;
         5: return d < 0 ? -3375 : 3375;
         7: return d < 0 ? -1953 : 1953;
         9: return d < 0 ? -1127 : 1127;
         11: return d < 0 ? -616 : 616;
         13: return d < 0 ? -305 : 305;
         default: return d < 0 ? -138 : 138;
      endcase
   endfunction

   // advance the loop by one sample and return the beat it produces
   function automatic vco_beat_type track_sample(logic signed [15:0] x);
      vco_beat_type b;
      longint acc, im, re, c, s, pd_re, pd_im, q, sig, total;
      logic [9:0] addr;
      acc = 0;
      ring[ring_ptr] = longint'(x);
      for (int k = 0; k < RING; k++)
         acc += ring[(ring_ptr + RING - k) % RING] * hilbert_coef(k);
      im = round_half_up(acc, 15);
      re = ring[(ring_ptr + RING - CENTER_TAP) % RING];
      ring_ptr = (ring_ptr + 1) % RING;
      addr = vco_phase_q[31:22];
      s = sine_lookup(addr);
      c = sine_lookup(addr + 10'd256);
      pd_re = round_half_up(re * c + im * s, 15);
      pd_im = round_half_up(im * c - re * s, 15);
      q = pd_re * pd_im;
      sig = integ_acc + round_half_up(q * longint'(integ_gain_q), 24);
      if (sig > 64'sd2147483647) sig = 64'sd2147483647;
      if (sig < -64'sd2147483648) sig = -64'sd2147483648;
      integ_acc = sig;
      total = longint'(rest_step_q) + sig + round_half_up(q * longint'(prop_gain_q), 24);
      if (total < 0) total = 0;
      if (total > 64'sd4294967295) total = 64'sd4294967295;
      vco_phase_q = vco_phase_q + total[31:0];
      b.cosine = c[15:0];
      b.sine   = s[15:0];
      b.step   = total[31:0];
      return b;
   endfunction

   task automatic send_sample(logic signed [15:0] x);
      req_valid <= 1'b1;
      req_received_sample <= x;
      do @(posedge clock); while (req_stall);
      pending_vco.push_back(track_sample(x));
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // drop valid and let the block drain before touching registers
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_vco.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_REST_STEP:  rest_step_q  = value;
         CSR_PROP_GAIN:  prop_gain_q  = value[23:0];
         CSR_INTEG_GAIN: integ_gain_q = value[23:0];
         default: ;
      endcase
   endtask

   task automatic set_loop(logic [31:0] rest, logic [31:0] kp, logic [31:0] ki);
      write_csr(CSR_REST_STEP, rest);
      write_csr(CSR_PROP_GAIN, kp);
      write_csr(CSR_INTEG_GAIN, ki);
   endtask

   task automatic send_tone(int count, logic [31:0] step, int amp);
      logic [31:0] ph;
      longint v;
      ph = $urandom;
      for (int i = 0; i < count; i++) begin
         v = (sine_lookup(ph[31:22]) * amp) >>> 15;
         send_sample(v[15:0]);
         ph += step;
      end
   endtask

   // receiver: stall in changing modes, or hold off on request
   initial begin
      int mode, left;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            rsp_stall <= 1'b1;
            hold_request--;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(50, 400);
            end
            left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ($urandom_range(0, 1) == 1);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      vco_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_vco.size() == 0) begin
            $display("%0t: unexpected beat cos=%0d sin=%0d step=%0h", $time,
                     rsp_vco_cosine, rsp_vco_sine, rsp_phase_step);
            errors++;
         end else begin
            e = pending_vco.pop_front();
            if (rsp_vco_cosine !== e.cosine) begin
               $display("%0t: cosine expected %0d got %0d", $time, e.cosine, rsp_vco_cosine);
               errors++;
            end
            if (rsp_vco_sine !== e.sine) begin
               $display("%0t: sine expected %0d got %0d", $time, e.sine, rsp_vco_sine);
               errors++;
            end
            if (rsp_phase_step !== e.step) begin
               $display("%0t: step expected %0h got %0h", $time, e.step, rsp_phase_step);
               errors++;
            end
         end
      end
   end

   task automatic test_extremes;
      logic signed [15:0] vals [6] = '{16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1,
                                      16'sh5555};
      foreach (vals[i]) send_sample(vals[i]);
      for (int i = 0; i < 6; i++) send_sample(i[0] ? -16'sd32768 : 16'sd32767);
      drain();
   endtask

   task automatic test_registers;
      set_loop(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 4; i++) send_sample(i[0] ? 16'sd32767 : -16'sd32768);
      drain();
      set_loop(32'hFFFF_FFFF, 32'd0, 32'd0);
      send_sample(16'sd12345);
      send_sample(-16'sd23456);
      drain();
      write_csr(CSR_UNUSED, 32'h1234_5678);
      set_loop(REST_STEP_RESET, PROP_GAIN_RESET, INTEG_GAIN_RESET);
      send_sample(16'sd1000);
      drain();
   endtask

   // full-scale tone far from the rest step pushes the integrator into its limits
   task automatic test_saturation;
      set_loop(32'h8000_0000, 32'hFF_FFFF, 32'hFF_FFFF);
      send_tone(40, 32'h1000_0000, 32767);
      drain();
   endtask

   task automatic test_backpressure;
      hold_request = 1500;
      send_tone(12, 32'h2000_0000, 20000);
      drain();
   endtask

   task automatic test_random;
      logic [31:0] rest;
      int n;
      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 3))
            0: set_loop(REST_STEP_RESET, PROP_GAIN_RESET, INTEG_GAIN_RESET);
            1: set_loop($urandom, $urandom, $urandom);
            2: set_loop($urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF,
                        $urandom_range(0, 1) ? 32'd0 : 32'hFF_FFFF,
                        $urandom_range(0, 1) ? 32'd0 : 32'hFF_FFFF);
            default: set_loop($urandom, $urandom_range(0, 400000), $urandom_range(0, 80000));
         endcase
         rest = rest_step_q;
         n = 0;
         while (n < 250) begin
            if ($urandom_range(0, 4) != 0) begin
               send_tone(40, rest + $urandom_range(0, 40000000) - 20000000,
                         $urandom_range(1000, 32767));
               n += 40;
            end else begin
               for (int i = 0; i < 10; i++) send_sample(16'($urandom));
               n += 10;
            end
         end
         drain();
      end
   endtask

   initial begin
      rest_step_q  = REST_STEP_RESET;
      prop_gain_q  = PROP_GAIN_RESET;
      integ_gain_q = INTEG_GAIN_RESET;
      foreach (ring[i]) ring[i] = 0;
      integ_acc   = 0;
      vco_phase_q = '0;
      ring_ptr    = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_registers();
      test_saturation();
      test_backpressure();
      test_random();
      repeat (200) @(posedge clock);
      if (errors == 0 && pending_vco.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
